### hdl/pf_pkg.sv
package pf_pkg;

    localparam int SIDE = 5;

    typedef logic [4:0] letter_t;

    // 5x5 key square, indexed [row][col]
    typedef logic [SIDE-1:0][SIDE-1:0][4:0] square_t;

    typedef logic [2:0] coord_t;

    typedef struct packed {
        letter_t first;
        letter_t second;
        logic    absent;
    } enc_result_t;

    localparam letter_t LET_I = 5'd8;
    localparam letter_t LET_J = 5'd9;
    localparam letter_t LET_Q = 5'd16;
    localparam letter_t LET_X = 5'd23;
    localparam letter_t LET_Z = 5'd25;

    localparam logic MODE_ENCRYPT = 1'b0;
    localparam logic MODE_DECRYPT = 1'b1;

    localparam int CFG_IDX_W = 2;
    localparam int CFG_DATA_W = 60;
    localparam logic [CFG_IDX_W-1:0] CFG_MODE        = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_SQUARE_LOW  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_SQUARE_HIGH = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_SQUARE_LAST = 2'd3;

    localparam coord_t COORD_MAX = 3'(SIDE - 1);

    function automatic coord_t wrap_inc(coord_t x);
        return (x == COORD_MAX) ? 3'd0 : 3'(x + 3'd1);
    endfunction

    function automatic coord_t wrap_dec(coord_t x);
        return (x == 3'd0) ? COORD_MAX : 3'(x - 3'd1);
    endfunction

endpackage

### hdl/pf_in_if.sv
interface pf_in_if;
    logic             valid;
    logic             ready;
    pf_pkg::letter_t  letter_in;
    logic             message_end;

    modport source (output valid, output letter_in, output message_end, input ready);
    modport sink   (input valid, input letter_in, input message_end, output ready);
endinterface

### hdl/pf_out_if.sv
interface pf_out_if;
    logic             valid;
    logic             ready;
    pf_pkg::letter_t  letter_out;
    logic             run_last;
    logic             not_in_square;

    modport source (output valid, output letter_out, output run_last, output not_in_square,
                    input ready);
    modport sink   (input valid, input letter_out, input run_last, input not_in_square,
                    output ready);
endinterface

### hdl/pf_pair_enc.sv
module pf_pair_enc (
    input  pf_pkg::square_t     square,
    input  logic                mode,
    input  pf_pkg::letter_t     a,
    input  pf_pkg::letter_t     b,
    output pf_pkg::enc_result_t result
);

    logic           a_hit;
    logic           b_hit;
    pf_pkg::coord_t ra, ca, rb, cb;
    pf_pkg::coord_t ra_n, ca_n, rb_n, cb_n;

    // Parallel compare; scanning high to low leaves the lowest matching index.
    always_comb
    begin
        a_hit = 1'b0;
        b_hit = 1'b0;
        ra = '0;
        ca = '0;
        rb = '0;
        cb = '0;
        for (int r = pf_pkg::SIDE - 1; r >= 0; r--)
        begin
            for (int c = pf_pkg::SIDE - 1; c >= 0; c--)
            begin
                if (square[r][c] == a)
                begin
                    a_hit = 1'b1;
                    ra = 3'(r);
                    ca = 3'(c);
                end
                if (square[r][c] == b)
                begin
                    b_hit = 1'b1;
                    rb = 3'(r);
                    cb = 3'(c);
                end
            end
        end
    end

    always_comb
    begin
        ra_n = ra;
        ca_n = ca;
        rb_n = rb;
        cb_n = cb;
        if (ra == rb)
        begin
            ca_n = (mode == pf_pkg::MODE_DECRYPT) ? pf_pkg::wrap_dec(ca) : pf_pkg::wrap_inc(ca);
            cb_n = (mode == pf_pkg::MODE_DECRYPT) ? pf_pkg::wrap_dec(cb) : pf_pkg::wrap_inc(cb);
        end
        else if (ca == cb)
        begin
            ra_n = (mode == pf_pkg::MODE_DECRYPT) ? pf_pkg::wrap_dec(ra) : pf_pkg::wrap_inc(ra);
            rb_n = (mode == pf_pkg::MODE_DECRYPT) ? pf_pkg::wrap_dec(rb) : pf_pkg::wrap_inc(rb);
        end
        else
        begin
            ca_n = cb;
            cb_n = ca;
        end

        if (a_hit && b_hit)
        begin
            result.first  = square[ra_n][ca_n];
            result.second = square[rb_n][cb_n];
            result.absent = 1'b0;
        end
        else
        begin
            // pass the pair through untouched and flag it
            result.first  = a;
            result.second = b;
            result.absent = 1'b1;
        end
    end

endmodule

### hdl/playfair_digraph_cipher_core.sv
// Playfair digraph cipher over a 5x5 key square loaded through the config port.
// Letters arrive one per transaction and are grouped into pairs (encrypt mode maps
// J to I and splits doubled letters with X, or Q for a doubled X; an odd tail
// is padded with Z in either mode). Each transaction yields 0, 2 or 4 cipher
// letters, run_last marking the final one. A letter passes through the pair
// register and then through the square lookup into the result register before
// its first result. The output port sends one letter per cycle while the
// receiver is ready, so sustained throughput is one result letter per cycle; a
// letter that completes no pair is accepted every cycle, and a letter that emits
// results holds the pair register until its last pair is taken. Config writes
// must only be made while no results are outstanding.
module playfair_digraph_cipher_core (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               cfg_we,
    input  logic [pf_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  logic [pf_pkg::CFG_DATA_W-1:0]      cfg_data,
    pf_in_if.sink                              letter_chan,
    pf_out_if.source                           cipher_chan
);

    // configuration
    logic                          mode_reg;
    logic [pf_pkg::CFG_DATA_W-1:0] sq_low_reg;
    logic [pf_pkg::CFG_DATA_W-1:0] sq_high_reg;
    pf_pkg::letter_t               sq_final_reg;
    pf_pkg::square_t               square;

    // text preparation
    pf_pkg::letter_t held_letter_reg, held_letter_next;
    logic            held_valid_reg, held_valid_next;

    // pair register: up to two pairs from one transaction
    logic            item_valid_reg, item_valid_next;
    logic            two_reg, two_next;
    logic            head_reg, head_next;
    pf_pkg::letter_t pa_reg [2];
    pf_pkg::letter_t pb_reg [2];
    pf_pkg::letter_t pa_next [2];
    pf_pkg::letter_t pb_next [2];

    // result register: one encoded pair, sent as two letters
    logic            res_valid_reg, res_valid_next;
    logic            res_idx_reg, res_idx_next;
    logic            res_last_reg;
    logic            res_flag_reg;
    pf_pkg::letter_t res_first_reg;
    pf_pkg::letter_t res_second_reg;

    pf_pkg::enc_result_t enc;
    pf_pkg::letter_t     let_prep;
    logic                dup;
    logic                in_fire;
    logic                out_fire;
    logic                res_free;
    logic                pop;
    logic                pop_last;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg     <= pf_pkg::MODE_ENCRYPT;
            sq_low_reg   <= '0;
            sq_high_reg  <= '0;
            sq_final_reg <= '0;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                pf_pkg::CFG_MODE:        mode_reg     <= cfg_data[0];
                pf_pkg::CFG_SQUARE_LOW:  sq_low_reg   <= cfg_data;
                pf_pkg::CFG_SQUARE_HIGH: sq_high_reg  <= cfg_data;
                pf_pkg::CFG_SQUARE_LAST: sq_final_reg <= cfg_data[4:0];
                default:                 mode_reg     <= mode_reg;
            endcase
        end
    end

    always_comb
    begin
        int k;
        k = 0;
        for (int r = 0; r < pf_pkg::SIDE; r++)
        begin
            for (int c = 0; c < pf_pkg::SIDE; c++)
            begin
                k = r * pf_pkg::SIDE + c;
                if (k < 12)
                    square[r][c] = sq_low_reg[5*k +: 5];
                else if (k < 24)
                    square[r][c] = sq_high_reg[5*(k-12) +: 5];
                else
                    square[r][c] = sq_final_reg;
            end
        end
    end

    // handshake
    assign out_fire = cipher_chan.valid && cipher_chan.ready;
    assign res_free = !res_valid_reg || (out_fire && res_idx_reg);
    assign pop      = item_valid_reg && res_free;
    assign pop_last = pop && (head_reg == two_reg);
    assign letter_chan.ready = !item_valid_reg || pop_last;
    assign in_fire  = letter_chan.valid && letter_chan.ready;

    // pairing of the incoming letter with the held one
    assign let_prep = (mode_reg == pf_pkg::MODE_ENCRYPT && letter_chan.letter_in == pf_pkg::LET_J)
                      ? pf_pkg::LET_I : letter_chan.letter_in;
    assign dup = (mode_reg == pf_pkg::MODE_ENCRYPT) && (held_letter_reg == let_prep);

    always_comb
    begin
        held_letter_next = held_letter_reg;
        held_valid_next  = held_valid_reg;
        item_valid_next  = item_valid_reg;
        two_next         = two_reg;
        head_next        = head_reg;
        pa_next[0]       = pa_reg[0];
        pb_next[0]       = pb_reg[0];
        pa_next[1]       = pa_reg[1];
        pb_next[1]       = pb_reg[1];

        if (pop)
        begin
            head_next = 1'b1;
            if (pop_last)
                item_valid_next = 1'b0;
        end

        if (in_fire)
        begin
            head_next  = 1'b0;
            two_next   = 1'b0;
            pa_next[1] = let_prep;
            pb_next[1] = pf_pkg::LET_Z;
            held_letter_next = letter_chan.message_end ? '0 : let_prep;
            if (held_valid_reg)
            begin
                item_valid_next = 1'b1;
                pa_next[0] = held_letter_reg;
                if (dup)
                begin
                    pb_next[0] = (let_prep == pf_pkg::LET_X) ? pf_pkg::LET_Q : pf_pkg::LET_X;
                    two_next   = letter_chan.message_end;
                end
                else
                begin
                    pb_next[0] = let_prep;
                end
                held_valid_next = dup && !letter_chan.message_end;
            end
            else
            begin
                // lone letter: a pair only when the message ends here
                item_valid_next = letter_chan.message_end;
                pa_next[0]      = let_prep;
                pb_next[0]      = pf_pkg::LET_Z;
                held_valid_next = !letter_chan.message_end;
            end
        end
    end

    pf_pair_enc u_enc (
        .square (square),
        .mode   (mode_reg),
        .a      (pa_reg[head_reg]),
        .b      (pb_reg[head_reg]),
        .result (enc)
    );

    always_comb
    begin
        res_valid_next = res_valid_reg;
        res_idx_next   = res_idx_reg;
        if (out_fire && !res_idx_reg)
            res_idx_next = 1'b1;
        else if (res_free)
        begin
            res_valid_next = pop;
            res_idx_next   = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            held_letter_reg <= '0;
            held_valid_reg  <= 1'b0;
            item_valid_reg  <= 1'b0;
            two_reg         <= 1'b0;
            head_reg        <= 1'b0;
            res_valid_reg   <= 1'b0;
            res_idx_reg     <= 1'b0;
        end
        else
        begin
            held_letter_reg <= held_letter_next;
            held_valid_reg  <= held_valid_next;
            item_valid_reg  <= item_valid_next;
            two_reg         <= two_next;
            head_reg        <= head_next;
            res_valid_reg   <= res_valid_next;
            res_idx_reg     <= res_idx_next;
        end
    end

    always_ff @(posedge clk)
    begin
        pa_reg[0] <= pa_next[0];
        pb_reg[0] <= pb_next[0];
        pa_reg[1] <= pa_next[1];
        pb_reg[1] <= pb_next[1];
        if (pop)
        begin
            res_first_reg  <= enc.first;
            res_second_reg <= enc.second;
            res_flag_reg   <= enc.absent;
            res_last_reg   <= (head_reg == two_reg);
        end
    end

    assign cipher_chan.valid         = res_valid_reg;
    assign cipher_chan.letter_out    = res_idx_reg ? res_second_reg : res_first_reg;
    assign cipher_chan.run_last      = res_last_reg && res_idx_reg;
    assign cipher_chan.not_in_square = res_flag_reg;

    // second letter of a pair always follows the first
    a_second_follows: assert property (@(posedge clk) disable iff (!rst_n)
        (out_fire && !res_idx_reg) |=> (res_valid_reg && res_idx_reg))
        else $error("second letter of pair lost");

    a_idx_needs_valid: assert property (@(posedge clk) disable iff (!rst_n)
        res_idx_reg |-> res_valid_reg)
        else $error("result index set on empty result register");

    a_end_flushes: assert property (@(posedge clk) disable iff (!rst_n)
        (in_fire && letter_chan.message_end) |=> !held_valid_reg)
        else $error("letter still held after message end");

    a_tail_pad: assert property (@(posedge clk) disable iff (!rst_n)
        (item_valid_reg && two_reg) |-> (pb_reg[1] == pf_pkg::LET_Z))
        else $error("second pair of a transaction is not a Z-padded tail");

    a_no_overrun: assert property (@(posedge clk) disable iff (!rst_n)
        (item_valid_reg && !pop) |=> (item_valid_reg && $stable(head_reg)))
        else $error("pair register changed while stalled");

endmodule

### verif/tb_top.sv
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    import pf_pkg::*;

    typedef struct {
        letter_t code;
        logic    fin;
    } plain_letter_t;

    typedef struct {
        letter_t letter;
        logic    last;
        logic    absent;
    } cipher_letter_t;

    logic clk = 1'b0;
    logic rst_n;
    logic cfg_we;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;

    pf_in_if  letter_chan();
    pf_out_if cipher_chan();

    playfair_digraph_cipher_core uut (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_we      (cfg_we),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .letter_chan (letter_chan),
        .cipher_chan (cipher_chan)
    );

    always #1 clk = ~clk;

    // shadow of the key registers and of the held letter
    logic                  key_mode;
    logic [CFG_DATA_W-1:0] key_low;
    logic [CFG_DATA_W-1:0] key_high;
    letter_t               key_last;
    letter_t               held_code;
    logic                  held_pending;

    plain_letter_t  pending_letters[$];
    cipher_letter_t expected_cipher[$];
    letter_t        square_plan[25];

    int items_queued;
    int items_sent;
    int results_seen;
    int mismatches;
    int regs_written;
    int key_settings;
    int send_gap;
    int send_calm;
    int recv_stall;
    int recv_calm;

    plain_letter_t  next_item;
    cipher_letter_t want;

    function automatic letter_t ltr(byte c);
        return letter_t'(c - 8'd65);
    endfunction

    function automatic letter_t square_entry(int k);
        if (k < 12)
            return key_low[5*k +: 5];
        if (k < 24)
            return key_high[5*(k-12) +: 5];
        return key_last;
    endfunction

    // lowest matching index wins when the square holds duplicates
    function automatic bit locate(letter_t l, output int pos);
        pos = 0;
        for (int k = 0; k < SIDE*SIDE; k++)
        begin
            if (square_entry(k) == l)
            begin
                pos = k;
                return 1'b1;
            end
        end
        return 1'b0;
    endfunction

    function automatic void encode_pair(letter_t a, letter_t b);
        int pa, pb, ra, ca, rb, cb, shift_by, t;
        bit miss;
        letter_t oa, ob;
        cipher_letter_t r;
        shift_by = (key_mode == MODE_DECRYPT) ? SIDE - 1 : 1;
        miss = 1'b0;
        if (!locate(a, pa))
            miss = 1'b1;
        else if (!locate(b, pb))
            miss = 1'b1;
        if (miss)
        begin
            oa = a;
            ob = b;
        end
        else
        begin
            ca = pa % SIDE;
            ra = pa / SIDE;
            cb = pb % SIDE;
            rb = pb / SIDE;
            if (ra == rb)
            begin
                ca = (ca + shift_by) % SIDE;
                cb = (cb + shift_by) % SIDE;
            end
            else if (ca == cb)
            begin
                ra = (ra + shift_by) % SIDE;
                rb = (rb + shift_by) % SIDE;
            end
            else
            begin
                t = ca;
                ca = cb;
                cb = t;
            end
            oa = square_entry(ra*SIDE + ca);
            ob = square_entry(rb*SIDE + cb);
        end
        r.last = 1'b0;
        r.absent = miss;
        r.letter = oa;
        expected_cipher.push_back(r);
        r.letter = ob;
        expected_cipher.push_back(r);
    endfunction

    function automatic void predict_cipher(letter_t l, logic fin);
        letter_t code;
        bit dec;
        int start_size;
        code = l;
        start_size = expected_cipher.size();
        dec = (key_mode == MODE_DECRYPT);
        if (!dec && code == LET_J)
            code = LET_I;
        if (held_pending)
        begin
            if (!dec && held_code == code)
            begin
                // doubled letter: filler closes the pair, the letter opens the next one
                encode_pair(held_code, (code == LET_X) ? LET_Q : LET_X);
                held_code = code;
            end
            else
            begin
                encode_pair(held_code, code);
                held_pending = 1'b0;
            end
        end
        else
        begin
            held_code = code;
            held_pending = 1'b1;
        end
        if (fin && held_pending)
        begin
            encode_pair(held_code, LET_Z);
            held_pending = 1'b0;
        end
        if (fin)
            held_code = '0;
        if (expected_cipher.size() > start_size)
            expected_cipher[expected_cipher.size()-1].last = 1'b1;
    endfunction

    // mostly short gaps, a few long, with stretches of none
    function automatic int idle_len(inout int calm);
        int r;
        if (calm > 0)
        begin
            calm--;
            return 0;
        end
        if ($urandom_range(0, 99) < 4)
        begin
            calm = $urandom_range(20, 80);
            return 0;
        end
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        if (r < 90)
            return $urandom_range(1, 3);
        return $urandom_range(6, 24);
    endfunction

    task automatic report_mismatch(string what);
        mismatches++;
        if (mismatches <= 40)
            $display("ERROR: cipher letter %0d: %s", results_seen, what);
    endtask

    // driver
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            letter_chan.valid <= 1'b0;
            letter_chan.letter_in <= '0;
            letter_chan.message_end <= 1'b0;
            send_gap = 0;
        end
        else
        begin
            if (letter_chan.valid && letter_chan.ready)
            begin
                predict_cipher(letter_chan.letter_in, letter_chan.message_end);
                items_sent++;
            end
            if (!letter_chan.valid || letter_chan.ready)
            begin
                if (send_gap > 0)
                begin
                    send_gap--;
                    letter_chan.valid <= 1'b0;
                end
                else if (pending_letters.size() > 0)
                begin
                    next_item = pending_letters.pop_front();
                    letter_chan.valid <= 1'b1;
                    letter_chan.letter_in <= next_item.code;
                    letter_chan.message_end <= next_item.fin;
                    send_gap = idle_len(send_calm);
                end
                else
                    letter_chan.valid <= 1'b0;
            end
        end
    end

    // monitor
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cipher_chan.ready <= 1'b0;
            recv_stall = 0;
        end
        else
        begin
            if (cipher_chan.valid && cipher_chan.ready)
            begin
                if (expected_cipher.size() == 0)
                    report_mismatch($sformatf("unexpected transaction, letter %0d",
                                              cipher_chan.letter_out));
                else
                begin
                    want = expected_cipher.pop_front();
                    if (cipher_chan.letter_out !== want.letter)
                        report_mismatch($sformatf("letter_out %0d, expected %0d",
                                                  cipher_chan.letter_out, want.letter));
                    if (cipher_chan.run_last !== want.last)
                        report_mismatch($sformatf("run_last %0b, expected %0b",
                                                  cipher_chan.run_last, want.last));
                    if (cipher_chan.not_in_square !== want.absent)
                        report_mismatch($sformatf("not_in_square %0b, expected %0b",
                                                  cipher_chan.not_in_square, want.absent));
                end
                results_seen++;
            end
            if (recv_stall > 0)
            begin
                recv_stall--;
                cipher_chan.ready <= 1'b0;
            end
            else
            begin
                cipher_chan.ready <= 1'b1;
                recv_stall = idle_len(recv_calm);
            end
        end
    end

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
        @(posedge clk);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= data;
        @(posedge clk);
        cfg_we <= 1'b0;
        case (idx)
            CFG_MODE:        key_mode = data[0];
            CFG_SQUARE_LOW:  key_low = data;
            CFG_SQUARE_HIGH: key_high = data;
            default:         key_last = data[4:0];
        endcase
        regs_written++;
    endtask

    task automatic load_square();
        logic [CFG_DATA_W-1:0] lo, hi;
        for (int k = 0; k < 12; k++)
        begin
            lo[5*k +: 5] = square_plan[k];
            hi[5*k +: 5] = square_plan[k+12];
        end
        write_reg(CFG_SQUARE_LOW, lo);
        write_reg(CFG_SQUARE_HIGH, hi);
        write_reg(CFG_SQUARE_LAST, CFG_DATA_W'(square_plan[24]));
        key_settings++;
    endtask

    // classic alphabet without J, optionally shuffled
    task automatic plan_standard(bit shuffle);
        letter_t t;
        int j;
        for (int k = 0; k < 25; k++)
            square_plan[k] = letter_t'((k < 9) ? k : k + 1);
        if (shuffle)
        begin
            for (int k = 24; k > 0; k--)
            begin
                j = $urandom_range(0, k);
                t = square_plan[k];
                square_plan[k] = square_plan[j];
                square_plan[j] = t;
            end
        end
    endtask

    // duplicates and codes above Z
    task automatic plan_wild();
        int r;
        for (int k = 0; k < 25; k++)
        begin
            r = $urandom_range(0, 99);
            if (r < 70 || k == 0)
                square_plan[k] = letter_t'($urandom_range(0, 25));
            else if (r < 85)
                square_plan[k] = square_plan[$urandom_range(0, k-1)];
            else
                square_plan[k] = letter_t'($urandom_range(26, 31));
        end
    endtask

    task automatic queue_item(letter_t code, logic fin);
        plain_letter_t it;
        it.code = code;
        it.fin = fin;
        pending_letters.push_back(it);
        items_queued++;
    endtask

    function automatic letter_t random_letter(letter_t prev);
        int r;
        r = $urandom_range(0, 99);
        if (r < 15)
            return prev;
        if (r < 27)
        begin
            case ($urandom_range(0, 4))
                0:       return LET_J;
                1:       return LET_X;
                2:       return LET_Z;
                3:       return LET_I;
                default: return LET_Q;
            endcase
        end
        if (r < 30)
            return letter_t'($urandom_range(26, 31));
        return letter_t'($urandom_range(0, 25));
    endfunction

    // whole messages of random length, the last one always closed
    task automatic queue_messages(int count);
        int left, len;
        letter_t prev;
        left = count;
        prev = '0;
        while (left > 0)
        begin
            len = $urandom_range(1, 10);
            if (len > left)
                len = left;
            for (int i = 0; i < len; i++)
            begin
                prev = random_letter(prev);
                queue_item(prev, i == len - 1);
            end
            left -= len;
        end
    endtask

    // wait until every queued letter is sent and every cipher letter is back, then let the pipe drain
    task automatic settle();
        while (items_sent != items_queued || expected_cipher.size() != 0)
            @(posedge clk);
        repeat (8) @(posedge clk);
    endtask

    initial
    begin
        #2_000_000;
        $display("playfair_digraph_cipher_core regression: fail");
        $finish;
    end

    initial
    begin
        rst_n = 1'b0;
        cfg_we = 1'b0;
        cfg_index = '0;
        cfg_data = '0;
        key_mode = MODE_ENCRYPT;
        key_low = '0;
        key_high = '0;
        key_last = '0;
        held_code = '0;
        held_pending = 1'b0;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        plan_standard(1'b0);
        load_square();
        write_reg(CFG_MODE, CFG_DATA_W'(MODE_ENCRYPT));
        queue_item(ltr("H"), 1'b0);     // rectangle
        queue_item(ltr("E"), 1'b0);
        queue_item(ltr("L"), 1'b0);     // doubled letter split by X
        queue_item(ltr("L"), 1'b0);
        queue_item(ltr("O"), 1'b1);
        queue_item(LET_X, 1'b0);        // doubled X split by Q, tail padded
        queue_item(LET_X, 1'b1);
        queue_item(ltr("A"), 1'b0);     // same row
        queue_item(ltr("B"), 1'b0);
        queue_item(ltr("E"), 1'b0);     // row wrap
        queue_item(ltr("A"), 1'b0);
        queue_item(ltr("A"), 1'b0);     // same column, wrap
        queue_item(ltr("V"), 1'b0);
        queue_item(LET_J, 1'b0);        // J folds to I, then doubles
        queue_item(LET_I, 1'b1);
        queue_item(LET_Z, 1'b1);        // lone Z pairs with the pad Z
        queue_item(ltr("K"), 1'b0);
        queue_item(ltr("Y"), 1'b1);
        queue_item(letter_t'(31), 1'b0);   // code outside the square
        queue_item(ltr("A"), 1'b1);
        settle();

        write_reg(CFG_MODE, CFG_DATA_W'(MODE_DECRYPT));
        queue_item(ltr("B"), 1'b0);     // equal letters take the row rule
        queue_item(ltr("B"), 1'b0);
        queue_item(LET_J, 1'b0);        // no J in the square
        queue_item(ltr("C"), 1'b1);
        queue_item(ltr("D"), 1'b1);
        queue_item(ltr("E"), 1'b0);
        queue_item(ltr("K"), 1'b1);
        settle();

        for (int p = 0; p < 8; p++)
        begin
            case (p)
                0, 6:
                begin
                    plan_standard(1'b1);
                    load_square();
                    write_reg(CFG_MODE, CFG_DATA_W'(MODE_ENCRYPT));
                end
                1, 7:
                begin
                    plan_standard(1'b1);
                    load_square();
                    write_reg(CFG_MODE, CFG_DATA_W'(MODE_DECRYPT));
                end
                2:
                begin
                    plan_wild();
                    load_square();
                    write_reg(CFG_MODE, CFG_DATA_W'(MODE_ENCRYPT));
                end
                3:
                begin
                    plan_wild();
                    load_square();
                    write_reg(CFG_MODE, CFG_DATA_W'(MODE_DECRYPT));
                end
                4:
                begin
                    write_reg(CFG_MODE, '1);
                    write_reg(CFG_SQUARE_LOW, '1);
                    write_reg(CFG_SQUARE_HIGH, '0);
                    write_reg(CFG_SQUARE_LAST, '1);
                    key_settings++;
                end
                default:
                begin
                    write_reg(CFG_MODE, CFG_DATA_W'(MODE_ENCRYPT));
                    write_reg(CFG_SQUARE_LOW, '0);
                    write_reg(CFG_SQUARE_HIGH, '1);
                    write_reg(CFG_SQUARE_LAST, CFG_DATA_W'(LET_Z));
                    key_settings++;
                end
            endcase
            queue_messages(48);
            settle();
        end

        if (expected_cipher.size() != 0)
            report_mismatch($sformatf("%0d cipher letters never arrived",
                                      expected_cipher.size()));
        $display("run covered %0d plaintext/ciphertext letters and %0d cipher letters checked,",
                 items_sent, results_seen);
        $display("across %0d key squares in both modes with %0d register writes",
                 key_settings, regs_written);
        if (mismatches == 0)
            $display("playfair_digraph_cipher_core regression: pass");
        else
            $display("playfair_digraph_cipher_core regression: fail");
        $finish;
    end

endmodule
